// ===== design/rbd_pkg.sv =====
// Shared types, request codes and default sizes for the ring buffer deque.
`default_nettype none
package rbd_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int REQ_W = 4;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int CNT_W = 7;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT     = 4'd2;
    localparam logic [REQ_W-1:0] REQ_GET        = 4'd3;
    localparam logic [REQ_W-1:0] REQ_SET        = 4'd4;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd5;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd6;
    localparam logic [REQ_W-1:0] REQ_REMOVE_AT  = 4'd7;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd8;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] data;
        logic [CNT_W-1:0] count;
    } t_rsp;

endpackage
`default_nettype wire

// ===== design/rbd_mem.sv =====
// Element store: one write port and one registered read port.
`default_nettype none
module rbd_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/rbd_ctrl.sv =====
// Request sequencer: decode, read, element shift loop, commit and result register.
`default_nettype none
module rbd_ctrl #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire rbd_pkg::t_req         i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output rbd_pkg::t_rsp              o_out_data,
    output logic                       o_mem_we,
    output logic      [AW-1:0]         o_mem_waddr,
    output logic      [DATA_WIDTH-1:0] o_mem_wdata,
    output logic                       o_mem_re,
    output logic      [AW-1:0]         o_mem_raddr,
    input  wire logic [DATA_WIDTH-1:0] i_mem_rdata
);
    import rbd_pkg::*;

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int SW = FW + 1;
    localparam int KW = (FW > POS_W) ? FW : POS_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_READ   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    function automatic logic [AW-1:0] f_at(logic [AW-1:0] b, logic [FW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(b) + SW'(k);
        if (s >= SW'(CAPACITY)) begin
            s = s - SW'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_inc(logic [AW-1:0] a);
        return (a == AW'(CAPACITY - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_dec(logic [AW-1:0] a);
        return (a == '0) ? AW'(CAPACITY - 1) : a - AW'(1);
    endfunction

    t_state                r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [FW-1:0]         r_fill, n_fill;
    logic [AW-1:0]         r_new_head, n_new_head;
    logic [FW-1:0]         r_new_fill, n_new_fill;
    logic [REQ_W-1:0]      r_req;
    logic [POS_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic                  r_ok, n_ok;
    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic                  r_fin_we, n_fin_we;
    logic [AW-1:0]         r_fin_addr, n_fin_addr;
    logic [AW-1:0]         r_src, n_src;
    logic [AW-1:0]         r_dst, n_dst;
    logic [FW-1:0]         r_left, n_left;
    logic                  r_asc, n_asc;
    logic                  r_pend, n_pend;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;

    logic                  accept;
    logic                  can_emit;
    logic [KW-1:0]         pos_k;
    logic [KW-1:0]         fill_k;
    logic [FW-1:0]         pos_f;
    logic                  not_full;
    logic                  not_empty;
    logic                  pos_le;
    logic                  pos_lt;
    logic                  ins_front;
    logic                  rem_front;
    logic [AW-1:0]         ap;
    logic [AW-1:0]         af;
    logic [63:0]           val_wide;
    logic [63:0]           data_wide;
    logic [KW-1:0]         cnt_k;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);
    assign can_emit   = !r_out_valid || i_out_ready;

    assign pos_k     = KW'(r_pos);
    assign fill_k    = KW'(r_fill);
    assign pos_f     = pos_k[FW-1:0];
    assign not_full  = (r_fill != FW'(CAPACITY));
    assign not_empty = (r_fill != '0);
    assign pos_le    = (pos_k <= fill_k);
    assign pos_lt    = (pos_k < fill_k);
    assign ins_front = ({pos_k, 1'b0} < {1'b0, fill_k});
    assign rem_front = ({pos_k, 1'b1} < {1'b0, fill_k});
    assign ap        = f_at(r_head, pos_f);
    assign af        = f_at(r_head, r_fill);
    assign val_wide  = 64'(i_in_data.value);
    assign data_wide = 64'(r_data);
    assign cnt_k     = KW'(r_new_fill);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_new_head  = r_new_head;
        n_new_fill  = r_new_fill;
        n_ok        = r_ok;
        n_data      = r_data;
        n_fin_we    = r_fin_we;
        n_fin_addr  = r_fin_addr;
        n_src       = r_src;
        n_dst       = r_dst;
        n_left      = r_left;
        n_asc       = r_asc;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_fin_addr;
        o_mem_wdata = r_val;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_src;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_ok       = 1'b0;
                n_data     = '0;
                n_fin_we   = 1'b0;
                n_new_head = r_head;
                n_new_fill = r_fill;
                n_pend     = 1'b0;
                n_left     = '0;
                n_state    = S_FINISH;
                unique case (r_req)
                    REQ_PUSH_FRONT: begin
                        if (not_full) begin
                            n_ok       = 1'b1;
                            n_fin_we   = 1'b1;
                            n_fin_addr = f_dec(r_head);
                            n_new_head = f_dec(r_head);
                            n_new_fill = r_fill + FW'(1);
                        end
                    end
                    REQ_PUSH_BACK: begin
                        if (not_full) begin
                            n_ok       = 1'b1;
                            n_fin_we   = 1'b1;
                            n_fin_addr = af;
                            n_new_fill = r_fill + FW'(1);
                        end
                    end
                    REQ_INSERT: begin
                        if (not_full && pos_le) begin
                            n_ok       = 1'b1;
                            n_fin_we   = 1'b1;
                            n_new_fill = r_fill + FW'(1);
                            n_state    = S_SHIFT;
                            if (ins_front) begin
                                n_src      = r_head;
                                n_dst      = f_dec(r_head);
                                n_asc      = 1'b1;
                                n_left     = pos_f;
                                n_fin_addr = f_dec(ap);
                                n_new_head = f_dec(r_head);
                            end else begin
                                n_src      = f_dec(af);
                                n_dst      = af;
                                n_asc      = 1'b0;
                                n_left     = r_fill - pos_f;
                                n_fin_addr = ap;
                            end
                        end
                    end
                    REQ_GET, REQ_SET, REQ_REMOVE_AT: begin
                        if (pos_lt) begin
                            n_ok        = 1'b1;
                            o_mem_re    = 1'b1;
                            o_mem_raddr = ap;
                            n_fin_addr  = ap;
                            n_fin_we    = (r_req == REQ_SET);
                            n_state     = S_READ;
                            if (r_req == REQ_REMOVE_AT) begin
                                n_new_fill = r_fill - FW'(1);
                                n_dst      = ap;
                                if (rem_front) begin
                                    n_src      = f_dec(ap);
                                    n_asc      = 1'b0;
                                    n_left     = pos_f;
                                    n_new_head = f_inc(r_head);
                                end else begin
                                    n_src  = f_inc(ap);
                                    n_asc  = 1'b1;
                                    n_left = r_fill - pos_f - FW'(1);
                                end
                            end
                        end
                    end
                    REQ_POP_FRONT: begin
                        if (not_empty) begin
                            n_ok        = 1'b1;
                            o_mem_re    = 1'b1;
                            o_mem_raddr = r_head;
                            n_new_head  = f_inc(r_head);
                            n_new_fill  = r_fill - FW'(1);
                            n_state     = S_READ;
                        end
                    end
                    REQ_POP_BACK: begin
                        if (not_empty) begin
                            n_ok        = 1'b1;
                            o_mem_re    = 1'b1;
                            o_mem_raddr = f_dec(af);
                            n_new_fill  = r_fill - FW'(1);
                            n_state     = S_READ;
                        end
                    end
                    REQ_CLEAR: begin
                        n_ok       = 1'b1;
                        n_new_head = '0;
                        n_new_fill = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_READ: begin
                n_data  = i_mem_rdata;
                n_state = (r_req == REQ_REMOVE_AT) ? S_SHIFT : S_FINISH;
            end
            S_SHIFT: begin
                // one word read and one written per cycle; reads run ahead of writes
                o_mem_re    = (r_left != '0);
                o_mem_raddr = r_src;
                o_mem_we    = r_pend;
                o_mem_waddr = r_dst;
                o_mem_wdata = i_mem_rdata;
                n_pend      = (r_left != '0);
                if (r_left != '0) begin
                    n_src  = r_asc ? f_inc(r_src) : f_dec(r_src);
                    n_left = r_left - FW'(1);
                end
                if (r_pend) begin
                    n_dst = r_asc ? f_inc(r_dst) : f_dec(r_dst);
                end
                if ((r_left == '0) && !r_pend) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_mem_we    = r_fin_we;
                o_mem_waddr = r_fin_addr;
                o_mem_wdata = r_val;
                n_head      = r_new_head;
                n_fill      = r_new_fill;
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out.ok    = r_ok;
                    n_out.data  = data_wide[VAL_W-1:0];
                    n_out.count = cnt_k[CNT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_left      <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_data.req_type;
            r_pos <= i_in_data.position;
            r_val <= val_wide[DATA_WIDTH-1:0];
        end
        r_new_head <= n_new_head;
        r_new_fill <= n_new_fill;
        r_ok       <= n_ok;
        r_data     <= n_data;
        r_fin_we   <= n_fin_we;
        r_fin_addr <= n_fin_addr;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_asc      <= n_asc;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== design/ring_buffer_indexed_deque_unit.sv =====
// Top level of the ring buffer deque: sequencer and element store.
// One request is in flight at a time. After the input transfer the request is decoded, then
// committed with its result registered for push, clear and any failed request; get, set and
// the pops read the store before the commit, an insert shifts words and a remove reads and
// then shifts. The shorter side of the list moves one word a cycle through the store's
// single read and write ports, so at most CAPACITY/2 moves. A new request can be taken in
// the cycle the result is presented. A result that is not taken holds the next request at its
// commit until it leaves the output register; a new request is taken while a presented result
// waits there. No clearing pass after reset.
`default_nettype none
module ring_buffer_indexed_deque_unit #(
    parameter int CAPACITY   = rbd_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rbd_pkg::t_req i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output rbd_pkg::t_rsp      o_out_data
);
    import rbd_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    rbd_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    rbd_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule
`default_nettype wire

// ===== bench/tb_ring_buffer_indexed_deque_unit.sv =====
// Self-checking bench for the ring buffer deque: directed and random requests against a list model.
`timescale 1ns / 1ps
module tb_ring_buffer_indexed_deque_unit;
    import rbd_pkg::*;

    localparam int DEPTH = CAPACITY_DEF;
    localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = 4'd9;
    localparam logic [REQ_W-1:0] REQ_LAST_UNUSED  = 4'd15;
    localparam int MAX_POS = (1 << POS_W) - 1;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} t_mix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    t_req i_in_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_rsp o_out_data;

    logic [VAL_W-1:0] held_words[$];
    t_rsp             pending_rsp[$];
    int               send_idle_pct = 35;
    int               recv_idle_pct = 47;
    int               mismatch_count = 0;

    ring_buffer_indexed_deque_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // list semantics of the deque; the result for one request
    function automatic t_rsp deque_response(input t_req r);
        t_rsp rsp;
        int   p;
        int   n;
        rsp = '0;
        p   = r.position;
        n   = held_words.size();
        case (r.req_type)
            REQ_PUSH_FRONT: if (n < DEPTH) begin
                held_words.push_front(r.value);
                rsp.ok = 1'b1;
            end
            REQ_PUSH_BACK: if (n < DEPTH) begin
                held_words.push_back(r.value);
                rsp.ok = 1'b1;
            end
            REQ_INSERT: if (n < DEPTH && p <= n) begin
                if (p == n) held_words.push_back(r.value);
                else held_words.insert(p, r.value);
                rsp.ok = 1'b1;
            end
            REQ_GET: if (p < n) begin
                rsp.data = held_words[p];
                rsp.ok   = 1'b1;
            end
            REQ_SET: if (p < n) begin
                rsp.data      = held_words[p];
                held_words[p] = r.value;
                rsp.ok        = 1'b1;
            end
            REQ_POP_FRONT: if (n > 0) begin
                rsp.data = held_words.pop_front();
                rsp.ok   = 1'b1;
            end
            REQ_POP_BACK: if (n > 0) begin
                rsp.data = held_words.pop_back();
                rsp.ok   = 1'b1;
            end
            REQ_REMOVE_AT: if (p < n) begin
                rsp.data = held_words[p];
                held_words.delete(p);
                rsp.ok   = 1'b1;
            end
            REQ_CLEAR: begin
                held_words.delete();
                rsp.ok = 1'b1;
            end
            default: ;
        endcase
        rsp.count = CNT_W'(held_words.size());
        return rsp;
    endfunction

    task automatic send_req(input logic [REQ_W-1:0] kind, input int pos,
                            input logic [VAL_W-1:0] word);
        t_req r;
        int   gap;
        r.req_type = kind;
        r.position = pos[POS_W-1:0];
        r.value    = word;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (!o_in_ready);
        pending_rsp.push_back(deque_response(r));
    endtask

    task automatic report_mismatch(input string what, input t_rsp want, input t_rsp got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected ok=%0d data=%h count=%0d, got ok=%0d data=%h count=%0d",
                     $time, what, want.ok, want.data, want.count, got.ok, got.data, got.count);
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("result with none outstanding", '0, o_out_data);
            end else begin
                want = pending_rsp.pop_front();
                if (o_out_data.ok !== want.ok)
                    report_mismatch("ok", want, o_out_data);
                else if (o_out_data.data !== want.data)
                    report_mismatch("data", want, o_out_data);
                else if (o_out_data.count !== want.count)
                    report_mismatch("count", want, o_out_data);
            end
        end
    end

    task automatic test_empty_store();
        send_req(REQ_POP_FRONT, 0, 32'h0);
        send_req(REQ_POP_BACK, 0, 32'h0);
        send_req(REQ_GET, 0, 32'h0);
        send_req(REQ_SET, 0, 32'hFFFF_FFFF);
        send_req(REQ_REMOVE_AT, 0, 32'h0);
        send_req(REQ_INSERT, 1, 32'h1234_5678);
        send_req(REQ_INSERT, 0, 32'hA5A5_5A5A);
        send_req(REQ_POP_BACK, 0, 32'h0);
    endtask

    task automatic test_indexed_ops();
        send_req(REQ_PUSH_BACK, 0, 32'hFFFF_FFFF);
        send_req(REQ_PUSH_FRONT, 0, 32'h0000_0000);
        send_req(REQ_INSERT, 1, 32'h1111_1111);
        send_req(REQ_INSERT, 0, 32'h2222_2222);
        send_req(REQ_INSERT, 4, 32'h3333_3333);
        send_req(REQ_INSERT, 6, 32'h4444_4444);
        send_req(REQ_INSERT, MAX_POS, 32'h5555_5555);
        send_req(REQ_GET, 0, 32'h0);
        send_req(REQ_GET, 4, 32'h0);
        send_req(REQ_GET, 5, 32'h0);
        send_req(REQ_SET, 2, 32'h8000_0001);
        send_req(REQ_SET, MAX_POS, 32'h0);
        send_req(REQ_REMOVE_AT, 1, 32'h0);
        send_req(REQ_REMOVE_AT, 3, 32'h0);
        send_req(REQ_REMOVE_AT, 3, 32'h0);
        send_req(REQ_REMOVE_AT, MAX_POS, 32'h0);
        send_req(REQ_POP_FRONT, 0, 32'h0);
        send_req(REQ_POP_BACK, 0, 32'h0);
    endtask

    task automatic test_clear_and_unknown();
        send_req(REQ_PUSH_BACK, 0, 32'hDEAD_BEEF);
        send_req(REQ_FIRST_UNUSED, 0, 32'hFFFF_FFFF);
        send_req(REQ_LAST_UNUSED, MAX_POS, 32'hFFFF_FFFF);
        send_req(REQ_CLEAR, MAX_POS, 32'hFFFF_FFFF);
        send_req(REQ_GET, 0, 32'h0);
        send_req(REQ_CLEAR, 0, 32'h0);
    endtask

    task automatic test_full_store();
        repeat (DEPTH) send_req(REQ_PUSH_BACK, 0, $urandom());
        send_req(REQ_PUSH_FRONT, 0, 32'h0);
        send_req(REQ_PUSH_BACK, 0, 32'h0);
        send_req(REQ_INSERT, 0, 32'h0);
        send_req(REQ_GET, DEPTH - 1, 32'h0);
        send_req(REQ_GET, DEPTH, 32'h0);
        send_req(REQ_SET, 0, 32'hFFFF_FFFF);
        send_req(REQ_REMOVE_AT, DEPTH / 2, 32'h0);
        send_req(REQ_INSERT, DEPTH / 2 - 1, 32'h0F0F_F0F0);
        send_req(REQ_REMOVE_AT, DEPTH / 2 - 1, 32'h0);
        send_req(REQ_INSERT, DEPTH / 2, 32'hF0F0_0F0F);
        while (held_words.size() > 0)
            send_req(REQ_REMOVE_AT, held_words.size() / 2, 32'h0);
    endtask

    task automatic test_random(input int n_items);
        t_mix mix;
        int   roll;
        int   pos;
        int   add_pct;
        int   rem_pct;
        logic [REQ_W-1:0] kind;
        logic [VAL_W-1:0] word;
        mix = MIX_CHURN;
        for (int i = 0; i < n_items; i++) begin
            if (i % 64 == 0) mix = t_mix'($urandom_range(0, 2));
            add_pct = (mix == MIX_GROW) ? 60 : (mix == MIX_SHRINK) ? 15 : 35;
            rem_pct = (mix == MIX_GROW) ? 15 : (mix == MIX_SHRINK) ? 60 : 35;
            roll = $urandom_range(0, 199);
            if (roll < 1) kind = REQ_CLEAR;
            else if (roll < 6)
                kind = REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
            else begin
                roll = $urandom_range(0, 99);
                if (roll < add_pct) begin
                    case ($urandom_range(0, 2))
                        0: kind = REQ_PUSH_FRONT;
                        1: kind = REQ_PUSH_BACK;
                        default: kind = REQ_INSERT;
                    endcase
                end else if (roll < add_pct + rem_pct) begin
                    case ($urandom_range(0, 2))
                        0: kind = REQ_POP_FRONT;
                        1: kind = REQ_POP_BACK;
                        default: kind = REQ_REMOVE_AT;
                    endcase
                end else begin
                    kind = $urandom_range(0, 1) ? REQ_GET : REQ_SET;
                end
            end
            if ($urandom_range(0, 9) == 0)
                pos = $urandom_range(0, MAX_POS);
            else if (kind == REQ_INSERT)
                pos = $urandom_range(0, held_words.size());
            else
                pos = (held_words.size() == 0) ? 0 : $urandom_range(0, held_words.size() - 1);
            case ($urandom_range(0, 15))
                0: word = '0;
                1: word = '1;
                default: word = $urandom();
            endcase
            send_req(kind, pos, word);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 35;
        recv_idle_pct = 47;
        test_empty_store();
        test_indexed_ops();
        test_clear_and_unknown();
        test_full_store();
        test_random(650);

        send_idle_pct = 47;
        recv_idle_pct = 35;
        test_random(650);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(650);

        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
